FILE: sv/bcs_pkg.sv
// shared types and constants for the between-class scatter block
`default_nettype none

package bcs_pkg;

  // sizes
  localparam int MAX_DIM     = 8;
  localparam int NUM_CLASSES = 16;
  localparam int COUNT_BITS  = 20;
  localparam int DIM_BITS    = 3;
  localparam int LABEL_BITS  = 4;
  localparam int CSUM_BITS   = 36;
  localparam int GSUM_BITS   = 40;
  localparam int TOTAL_BITS  = 25;
  localparam int CNT_W       = COUNT_BITS + 1;
  localparam int ENTRY_BITS  = 58;
  localparam int MEAN_BITS   = 32;
  localparam int DIFF_BITS   = 33;
  localparam int ADDR_BITS   = LABEL_BITS + DIM_BITS;
  localparam int ACC_BITS    = 2 * DIM_BITS;

  // opcodes
  localparam logic [1:0] OP_SAMPLE  = 2'd0;
  localparam logic [1:0] OP_COMPUTE = 2'd1;
  localparam logic [1:0] OP_CLEAR   = 2'd2;

  // config register index
  localparam logic REG_DIM = 1'b0;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [15:0] element_value;
    logic [3:0]         class_label;
    logic               last_element;
  } in_t;

  typedef struct packed {
    logic signed [ENTRY_BITS-1:0] scatter_entry;
    logic [2:0]                   row_index;
    logic [2:0]                   column_index;
    logic                         status;
    logic                         last_entry;
  } out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GDIV,
    ST_GWAIT,
    ST_CSCAN,
    ST_CRD,
    ST_CDIV,
    ST_CWAIT,
    ST_OPA,
    ST_OPB,
    ST_MLO,
    ST_MHI,
    ST_ACC,
    ST_ERD,
    ST_ELD,
    ST_EWAIT
  } state_t;

endpackage

`default_nettype wire

FILE: sv/bcs_div.sv
// radix-2 restoring divider forming a rounded, clamped q16 mean
`default_nettype none

module bcs_div
  import bcs_pkg::*;
(
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic signed [GSUM_BITS-1:0]  sum,
  input  wire logic [TOTAL_BITS-1:0]        count,
  output logic                              done,
  output logic signed [MEAN_BITS-1:0]       mean
);

  localparam int NUM_W = GSUM_BITS + 16;

  logic [NUM_W-1:0]      num_r;
  logic [TOTAL_BITS-1:0] rem_r;
  logic [TOTAL_BITS-1:0] dvs_r;
  logic [5:0]            cnt_r;
  logic                  busy_r;
  logic                  neg_r;
  logic                  done_r;
  logic signed [MEAN_BITS-1:0] mean_r;

  logic [GSUM_BITS-1:0]  mag;
  logic [TOTAL_BITS:0]   rem_sh;
  logic                  ge;
  logic [TOTAL_BITS:0]   rem_sub;
  logic [NUM_W-1:0]      qfin;
  logic [MEAN_BITS-1:0]  qsat;
  logic [MEAN_BITS-1:0]  res;

  // one quotient bit per step
  always_comb begin
    mag     = sum[GSUM_BITS-1] ? (~sum + 1'b1) : sum;
    rem_sh  = {rem_r, num_r[NUM_W-1]};
    ge      = rem_sh >= {1'b0, dvs_r};
    rem_sub = rem_sh - {1'b0, dvs_r};
    qfin    = {num_r[NUM_W-2:0], ge};
    qsat    = (|qfin[NUM_W-1:MEAN_BITS-1]) ? 32'h8000_0000 : qfin[MEAN_BITS-1:0];
    if (neg_r) begin
      res = ~qsat + 1'b1;
    end else begin
      res = qsat[MEAN_BITS-1] ? 32'h7fff_ffff : qsat;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'(NUM_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= {mag, 16'b0} + NUM_W'(count >> 1);
      rem_r <= '0;
      dvs_r <= count;
      neg_r <= sum[GSUM_BITS-1];
    end else if (busy_r) begin
      num_r <= qfin;
      rem_r <= ge ? rem_sub[TOTAL_BITS-1:0] : rem_sh[TOTAL_BITS-1:0];
      if (cnt_r == 6'd0) begin
        mean_r <= res;
      end
    end
  end

  assign done = done_r;
  assign mean = mean_r;

endmodule

`default_nettype wire

FILE: sv/between_class_scatter.sv
// top level: sample accumulation, scatter compute sequencer and result output
//
//  channel  direction  handshake              payload
//  in_      input      in_valid / in_stall    in_data  (in_t)
//  out_     output     out_valid / out_stall  out_data (out_t)
//  cfg_     input      apb psel/penable       dimension_in_use at byte 0
//
// sample elements and clears are taken back to back while idle; a sample is
// a two stage read-modify-write on the class sum memory with forwarding.
// a compute forms the global means on the serial divider, scans the classes,
// forms the means of each class with samples and multiplies their differences
// on the shared split multiplier, then sends the entries while out_stall is low.
// reset is synchronous; no clearing pass, the class sum memory has valid bits.
// in_stall is high for the whole compute; out_stall holds the current result.
`default_nettype none

module between_class_scatter
  import bcs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_t         in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_t             out_data,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(1) << COUNT_BITS;
  localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;

  function automatic logic signed [CSUM_BITS-1:0] sat_c(input logic signed [CSUM_BITS:0] x);
    logic signed [CSUM_BITS:0] hi;
    logic signed [CSUM_BITS:0] lo;
    hi = (CSUM_BITS+1)'((64'd1 << (CSUM_BITS - 1)) - 64'd1);
    lo = ~hi;
    if (x > hi) return hi[CSUM_BITS-1:0];
    if (x < lo) return lo[CSUM_BITS-1:0];
    return x[CSUM_BITS-1:0];
  endfunction

  function automatic logic signed [GSUM_BITS-1:0] sat_g(input logic signed [GSUM_BITS:0] x);
    logic signed [GSUM_BITS:0] hi;
    logic signed [GSUM_BITS:0] lo;
    hi = (GSUM_BITS+1)'((64'd1 << (GSUM_BITS - 1)) - 64'd1);
    lo = ~hi;
    if (x > hi) return hi[GSUM_BITS-1:0];
    if (x < lo) return lo[GSUM_BITS-1:0];
    return x[GSUM_BITS-1:0];
  endfunction

  // configuration
  logic [3:0] dim_r;
  logic [3:0] dim_eff;
  logic       cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr[2] == REG_DIM) ? {28'b0, dim_r} : 32'b0;
  assign dim_eff = (dim_r == 4'd0) ? 4'd1 :
                   (dim_r > 4'(MAX_DIM)) ? 4'(MAX_DIM) : dim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_r <= 4'(MAX_DIM);
    end else if (cfg_wr && cfg_paddr[2] == REG_DIM) begin
      dim_r <= cfg_pwdata[3:0];
    end
  end

  // state and sequencer registers
  state_t state_r, state_nxt;
  logic [LABEL_BITS-1:0] c_r;
  logic [DIM_BITS-1:0]   i_r, j_r;
  logic                  first_r;

  logic in_take, do_sample, do_compute, do_clear;
  assign in_stall   = (state_r != ST_IDLE);
  assign in_take    = in_valid && !in_stall;
  assign do_sample  = in_take && in_data.opcode == OP_SAMPLE;
  assign do_compute = in_take && in_data.opcode == OP_COMPUTE;
  assign do_clear   = in_take && in_data.opcode == OP_CLEAR;

  logic last_i, last_j, last_c;
  assign last_i = ({1'b0, i_r} == dim_eff - 4'd1);
  assign last_j = ({1'b0, j_r} == dim_eff - 4'd1);
  assign last_c = (c_r == LABEL_BITS'(NUM_CLASSES - 1));

  // accumulators in flops
  logic signed [GSUM_BITS-1:0] gsum_r [MAX_DIM];
  logic [CNT_W-1:0]            cnt_r  [NUM_CLASSES];
  logic [TOTAL_BITS-1:0]       total_r;
  logic [DIM_BITS-1:0]         pos_r;

  logic [DIM_BITS-1:0]   gidx;
  logic [LABEL_BITS-1:0] cidx;
  logic signed [GSUM_BITS-1:0] g_cur;
  logic [CNT_W-1:0]      c_cur;
  logic                  ends, take;

  assign gidx  = (state_r == ST_IDLE) ? pos_r : i_r;
  assign cidx  = (state_r == ST_IDLE) ? in_data.class_label : c_r;
  assign g_cur = gsum_r[gidx];
  assign c_cur = cnt_r[cidx];
  assign ends  = in_data.last_element || ({1'b0, pos_r} + 4'd1 >= dim_eff);
  assign take  = c_cur < CNT_FULL;

  // stage 0 of a sample: flop accumulators, position and counts
  always_ff @(posedge clk) begin
    if (!rst_n || do_clear) begin
      for (int k = 0; k < MAX_DIM; k++) gsum_r[k] <= '0;
      for (int k = 0; k < NUM_CLASSES; k++) cnt_r[k] <= '0;
      total_r <= '0;
      pos_r   <= '0;
    end else if (do_sample) begin
      pos_r <= ends ? '0 : pos_r + 1'b1;
      if (take) begin
        gsum_r[pos_r] <= sat_g((GSUM_BITS+1)'(g_cur) + (GSUM_BITS+1)'(in_data.element_value));
        if (ends) begin
          cnt_r[in_data.class_label] <= c_cur + 1'b1;
          if (total_r != TOTAL_MAX) total_r <= total_r + 1'b1;
        end
      end
    end
  end

  // class sum memory with valid bits
  logic signed [CSUM_BITS-1:0] cs_mem [NUM_CLASSES * MAX_DIM];
  logic [NUM_CLASSES*MAX_DIM-1:0] cs_vld_r;
  logic [ADDR_BITS-1:0]        cs_raddr;
  logic signed [CSUM_BITS-1:0] cs_q_r;
  logic                        cs_vq_r;

  logic                        s1_valid_r;
  logic [ADDR_BITS-1:0]        s1_addr_r;
  logic signed [15:0]          s1_val_r;
  logic                        fwd_valid_r;
  logic [ADDR_BITS-1:0]        fwd_addr_r;
  logic signed [CSUM_BITS-1:0] fwd_data_r;
  logic signed [CSUM_BITS-1:0] s1_old;
  logic signed [CSUM_BITS-1:0] s1_new;

  assign cs_raddr = (state_r == ST_IDLE) ? {in_data.class_label, pos_r} : {c_r, i_r};

  // stage 1 of a sample: add to the class sum, forwarding the last write
  always_comb begin
    if (fwd_valid_r && fwd_addr_r == s1_addr_r) begin
      s1_old = fwd_data_r;
    end else begin
      s1_old = cs_vq_r ? cs_q_r : '0;
    end
    s1_new = sat_c((CSUM_BITS+1)'(s1_old) + (CSUM_BITS+1)'(s1_val_r));
  end

  always_ff @(posedge clk) begin
    cs_q_r  <= cs_mem[cs_raddr];
    cs_vq_r <= cs_vld_r[cs_raddr];
    if (s1_valid_r) begin
      cs_mem[s1_addr_r] <= s1_new;
    end
    s1_addr_r  <= {in_data.class_label, pos_r};
    s1_val_r   <= in_data.element_value;
    fwd_addr_r <= s1_addr_r;
    fwd_data_r <= s1_new;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || do_clear) begin
      cs_vld_r    <= '0;
      s1_valid_r  <= 1'b0;
      fwd_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= do_sample && take;
      fwd_valid_r <= s1_valid_r;
      if (s1_valid_r) cs_vld_r[s1_addr_r] <= 1'b1;
    end
  end

  // shared mean divider
  logic                        div_start;
  logic signed [GSUM_BITS-1:0] div_sum;
  logic [TOTAL_BITS-1:0]       div_cnt;
  logic                        div_done;
  logic signed [MEAN_BITS-1:0] div_mean;

  assign div_start = (state_r == ST_GDIV) || (state_r == ST_CDIV);
  assign div_sum   = (state_r == ST_GDIV) ? g_cur :
                     (cs_vq_r ? GSUM_BITS'(cs_q_r) : '0);
  assign div_cnt   = (state_r == ST_GDIV) ? total_r : TOTAL_BITS'(c_cur);

  bcs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .sum   (div_sum),
    .count (div_cnt),
    .done  (div_done),
    .mean  (div_mean)
  );

  // means and differences
  logic signed [MEAN_BITS-1:0] gmean_r [MAX_DIM];
  logic signed [DIFF_BITS-1:0] diff_r  [MAX_DIM];
  logic [DIM_BITS-1:0]         dsel;
  logic signed [DIFF_BITS-1:0] dcur;
  logic [DIFF_BITS-1:0]        dmag;

  assign dsel = (state_r == ST_OPA) ? i_r : j_r;
  assign dcur = diff_r[dsel];
  assign dmag = dcur[DIFF_BITS-1] ? (~dcur + 1'b1) : dcur;

  always_ff @(posedge clk) begin
    if (state_r == ST_GWAIT && div_done) begin
      gmean_r[i_r] <= div_mean;
    end
    if (state_r == ST_CWAIT && div_done) begin
      diff_r[i_r] <= DIFF_BITS'(div_mean) - DIFF_BITS'(gmean_r[i_r]);
    end
  end

  // split multiplier and accumulate
  logic [DIFF_BITS-1:0] a_r, b_r;
  logic                 a_neg_r, b_neg_r;
  logic [48:0]          pp_r;
  logic [63:0]          prod_r;
  logic [63:0]          prod_rnd;
  logic signed [ENTRY_BITS-1:0] term;
  logic signed [ENTRY_BITS-1:0] acc_mem [MAX_DIM * MAX_DIM];
  logic signed [ENTRY_BITS-1:0] acc_q_r;
  logic [ACC_BITS-1:0]  acc_addr;

  assign acc_addr = {i_r, j_r};
  assign prod_rnd = prod_r + 64'h8000;
  assign term = (a_neg_r ^ b_neg_r) ? -ENTRY_BITS'(prod_rnd[63:16])
                                    : ENTRY_BITS'(prod_rnd[63:16]);

  always_ff @(posedge clk) begin
    if (state_r == ST_OPA) begin
      a_r     <= dmag;
      a_neg_r <= dcur[DIFF_BITS-1];
    end
    if (state_r == ST_OPB) begin
      b_r     <= dmag;
      b_neg_r <= dcur[DIFF_BITS-1];
    end
    pp_r   <= a_r * b_r[15:0];
    prod_r <= 64'(pp_r) + (64'(a_r * b_r[DIFF_BITS-1:16]) << 16);
    acc_q_r <= acc_mem[acc_addr];
    if (state_r == ST_ACC) begin
      acc_mem[acc_addr] <= first_r ? term : acc_q_r + term;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (do_compute) state_nxt = (total_r == '0) ? ST_EWAIT : ST_GDIV;
      end
      ST_GDIV:  state_nxt = ST_GWAIT;
      ST_GWAIT: begin
        if (div_done) state_nxt = last_i ? ST_CSCAN : ST_GDIV;
      end
      ST_CSCAN: begin
        if (c_cur != '0) state_nxt = ST_CRD;
        else if (last_c) state_nxt = ST_ERD;
      end
      ST_CRD:   state_nxt = ST_CDIV;
      ST_CDIV:  state_nxt = ST_CWAIT;
      ST_CWAIT: begin
        if (div_done) state_nxt = last_i ? ST_OPA : ST_CRD;
      end
      ST_OPA:   state_nxt = ST_OPB;
      ST_OPB:   state_nxt = ST_MLO;
      ST_MLO:   state_nxt = ST_MHI;
      ST_MHI:   state_nxt = ST_ACC;
      ST_ACC: begin
        if (last_i && last_j) state_nxt = last_c ? ST_ERD : ST_CSCAN;
        else state_nxt = ST_OPA;
      end
      ST_ERD:   state_nxt = ST_ELD;
      ST_ELD:   state_nxt = ST_EWAIT;
      ST_EWAIT: begin
        if (!out_stall) state_nxt = out_data.last_entry ? ST_IDLE : ST_ERD;
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // loop indices
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_r     <= '0;
      i_r     <= '0;
      j_r     <= '0;
      first_r <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          c_r     <= '0;
          i_r     <= '0;
          j_r     <= '0;
          first_r <= 1'b1;
        end
        ST_GWAIT: begin
          if (div_done) i_r <= last_i ? '0 : i_r + 1'b1;
        end
        ST_CSCAN: begin
          i_r <= '0;
          j_r <= '0;
          if (c_cur == '0 && !last_c) c_r <= c_r + 1'b1;
        end
        ST_CWAIT: begin
          if (div_done) i_r <= last_i ? '0 : i_r + 1'b1;
        end
        ST_ACC: begin
          if (last_j) begin
            j_r <= '0;
            i_r <= last_i ? '0 : i_r + 1'b1;
            if (last_i) begin
              first_r <= 1'b0;
              if (!last_c) c_r <= c_r + 1'b1;
            end
          end else begin
            j_r <= j_r + 1'b1;
          end
        end
        ST_EWAIT: begin
          if (!out_stall) begin
            if (last_j) begin
              j_r <= '0;
              i_r <= i_r + 1'b1;
            end else begin
              j_r <= j_r + 1'b1;
            end
          end
        end
        default: begin
          c_r <= c_r;
        end
      endcase
    end
  end

  // output register
  out_t out_r;
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_IDLE && do_compute && total_r == '0) begin
      out_valid_r <= 1'b1;
    end else if (state_r == ST_ELD) begin
      out_valid_r <= 1'b1;
    end else if (state_r == ST_EWAIT && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE) begin
      out_r.scatter_entry <= '0;
      out_r.row_index     <= '0;
      out_r.column_index  <= '0;
      out_r.status        <= 1'b1;
      out_r.last_entry    <= 1'b1;
    end else if (state_r == ST_ELD) begin
      out_r.scatter_entry <= acc_q_r;
      out_r.row_index     <= i_r;
      out_r.column_index  <= j_r;
      out_r.status        <= 1'b0;
      out_r.last_entry    <= last_i && last_j;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire
